// ----- hw/rtl/asn1_time_string_parser_macros.svh -----
// Assertion helpers for the time string parser.
`ifndef ASN1_TIME_STRING_PARSER_MACROS_SVH
`define ASN1_TIME_STRING_PARSER_MACROS_SVH

// Checked only outside reset.
`define A1TS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every edge, reset included.
`define A1TS_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- hw/rtl/asn1ts_pkg.sv -----
`default_nettype none
package asn1ts_pkg;

  localparam logic [7:0] TAG_UTC = 8'h17;
  localparam logic [7:0] TAG_GEN = 8'h18;
  localparam logic [7:0] CHAR_0  = 8'h30;
  localparam logic [7:0] CHAR_9  = 8'h39;
  localparam logic [7:0] CHAR_Z  = 8'h5A;

  localparam logic [4:0] POS_MAX = 5'd31;

  localparam logic [1:0] ST_OK  = 2'd0;
  localparam logic [1:0] ST_TAG = 2'd1;
  localparam logic [1:0] ST_FMT = 2'd2;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       first;
    logic       last;
  } asn1ts_in_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [13:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  second;
  } asn1ts_out_t;

  typedef struct packed {
    logic       valid;
    asn1ts_in_t word;
  } asn1ts_step_t;

  typedef struct packed {
    logic        load;
    asn1ts_out_t res;
  } asn1ts_emit_t;

  function automatic logic [6:0] acc_digit(input logic [6:0] acc, input logic [3:0] d);
    logic [10:0] t;
    t = 11'(acc) * 11'd10 + 11'(d);
    return t[6:0];
  endfunction

  // (2*tens + ones) mod 4 == 0 for a two-digit decimal group
  function automatic logic div4(input logic [3:0] tens, input logic [3:0] ones);
    logic [1:0] t;
    t = {tens[0], 1'b0} + ones[1:0];
    return t == 2'd0;
  endfunction

  function automatic logic [4:0] days_in_month(input logic [6:0] mon, input logic leap);
    logic [4:0] len;
    case (mon) inside
      7'd1, 7'd3, 7'd5, 7'd7, 7'd8, 7'd10, 7'd12: len = 5'd31;
      7'd4, 7'd6, 7'd9, 7'd11:                     len = 5'd30;
      7'd2:                                        len = leap ? 5'd29 : 5'd28;
      default:                                     len = 5'd0;
    endcase
    return len;
  endfunction

endpackage
`default_nettype wire

// ----- hw/rtl/asn1ts_in_stage.sv -----
`default_nettype none
module asn1ts_in_stage
  import asn1ts_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_valid,
  output logic              in_ready,
  input  wire asn1ts_in_t   in_data,
  input  wire logic         take,
  output asn1ts_step_t      step
);

  logic       valid_r;
  asn1ts_in_t data_r;

  assign in_ready   = !valid_r || take;
  assign step.valid = valid_r;
  assign step.word  = data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      data_r <= in_data;
    end
  end

endmodule
`default_nettype wire

// ----- hw/rtl/asn1ts_core.sv -----
`default_nettype none
module asn1ts_core
  import asn1ts_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire asn1ts_step_t step,
  input  wire logic         can_load,
  output logic              take,
  output asn1ts_emit_t      emit
);

  logic [4:0]       pos_r, pos_nxt;
  logic             gen_r, gen_nxt;
  logic [1:0]       err_r, err_nxt;
  logic [13:0]      year_r, year_nxt;
  logic [6:0]       mon_r, mon_nxt;
  logic [6:0]       day_r, day_nxt;
  logic [6:0]       hour_r, hour_nxt;
  logic [6:0]       min_r, min_nxt;
  logic [6:0]       sec_r, sec_nxt;
  logic [3:0][3:0]  ydig_r, ydig_nxt;

  asn1ts_in_t  w;
  logic [4:0]  ylen;
  logic [4:0]  ylen_n;
  logic [4:0]  rel;
  logic [2:0]  fld;
  logic        is_digit;
  logic [7:0]  dbyte;
  logic [3:0]  dig;
  logic [17:0] year_mul;
  logic [13:0] yr_full;
  logic        leap;
  logic        lo_zero;
  logic [4:0]  mlen;
  logic [1:0]  status;

  assign w    = step.word;
  assign take = step.valid && (!w.last || can_load);

  always_comb begin
    pos_nxt  = pos_r;
    gen_nxt  = gen_r;
    err_nxt  = err_r;
    year_nxt = year_r;
    mon_nxt  = mon_r;
    day_nxt  = day_r;
    hour_nxt = hour_r;
    min_nxt  = min_r;
    sec_nxt  = sec_r;
    ydig_nxt = ydig_r;

    ylen     = gen_r ? 5'd4 : 5'd2;
    rel      = pos_r - ylen;
    fld      = rel[3:1];
    is_digit = (w.data_byte >= CHAR_0) && (w.data_byte <= CHAR_9);
    dbyte    = w.data_byte - CHAR_0;
    dig      = dbyte[3:0];
    year_mul = 18'(year_r) * 18'd10 + 18'(dig);

    if (w.first) begin
      pos_nxt  = '0;
      gen_nxt  = 1'b0;
      err_nxt  = ST_OK;
      year_nxt = '0;
      mon_nxt  = '0;
      day_nxt  = '0;
      hour_nxt = '0;
      min_nxt  = '0;
      sec_nxt  = '0;
      ydig_nxt = '0;
      if (w.data_byte == TAG_GEN) begin
        gen_nxt = 1'b1;
      end else if (w.data_byte != TAG_UTC) begin
        err_nxt = ST_TAG;
      end
    end else begin
      if (err_r == ST_OK) begin
        if (pos_r < ylen + 5'd10) begin
          if (!is_digit) begin
            err_nxt = ST_FMT;
          end else if (pos_r < ylen) begin
            year_nxt = year_mul[13:0];
            ydig_nxt = {ydig_r[2:0], dig};
          end else begin
            case (fld)
              3'd0:    mon_nxt  = acc_digit(mon_r, dig);
              3'd1:    day_nxt  = acc_digit(day_r, dig);
              3'd2:    hour_nxt = acc_digit(hour_r, dig);
              3'd3:    min_nxt  = acc_digit(min_r, dig);
              default: sec_nxt  = acc_digit(sec_r, dig);
            endcase
          end
        end else if (!(pos_r == ylen + 5'd10 && w.data_byte == CHAR_Z)) begin
          err_nxt = ST_FMT;
        end
      end
      if (pos_r != POS_MAX) begin
        pos_nxt = pos_r + 5'd1;
      end
    end
  end

  // result check on the updated state
  always_comb begin
    ylen_n = gen_nxt ? 5'd4 : 5'd2;
    if (gen_nxt) begin
      yr_full = year_nxt;
    end else if (year_nxt < 14'd50) begin
      yr_full = year_nxt + 14'd2000;
    end else begin
      yr_full = year_nxt + 14'd1900;
    end
    lo_zero = (ydig_nxt[1] == 4'd0) && (ydig_nxt[0] == 4'd0);
    if (!lo_zero) begin
      leap = div4(ydig_nxt[1], ydig_nxt[0]);
    end else if (gen_nxt) begin
      leap = div4(ydig_nxt[3], ydig_nxt[2]);
    end else begin
      leap = 1'b1;
    end
    mlen = days_in_month(mon_nxt, leap);

    status = err_nxt;
    if (status == ST_OK && pos_nxt != ylen_n + 5'd10 && pos_nxt != ylen_n + 5'd11) begin
      status = ST_FMT;
    end
    if (status == ST_OK) begin
      if (yr_full > 14'd9999 || hour_nxt > 7'd23 || min_nxt > 7'd59 || sec_nxt > 7'd59 ||
          mlen == 5'd0 || day_nxt < 7'd1 || day_nxt > 7'(mlen)) begin
        status = ST_FMT;
      end
    end

    emit.load       = take && w.last;
    emit.res.status = status;
    if (status == ST_OK) begin
      emit.res.year   = yr_full;
      emit.res.month  = mon_nxt[3:0];
      emit.res.day    = day_nxt[4:0];
      emit.res.hour   = hour_nxt[4:0];
      emit.res.minute = min_nxt[5:0];
      emit.res.second = sec_nxt[5:0];
    end else begin
      emit.res.year   = '0;
      emit.res.month  = '0;
      emit.res.day    = '0;
      emit.res.hour   = '0;
      emit.res.minute = '0;
      emit.res.second = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || (take && w.last)) begin
      pos_r  <= '0;
      gen_r  <= 1'b0;
      err_r  <= ST_OK;
      year_r <= '0;
      mon_r  <= '0;
      day_r  <= '0;
      hour_r <= '0;
      min_r  <= '0;
      sec_r  <= '0;
      ydig_r <= '0;
    end else if (take) begin
      pos_r  <= pos_nxt;
      gen_r  <= gen_nxt;
      err_r  <= err_nxt;
      year_r <= year_nxt;
      mon_r  <= mon_nxt;
      day_r  <= day_nxt;
      hour_r <= hour_nxt;
      min_r  <= min_nxt;
      sec_r  <= sec_nxt;
      ydig_r <= ydig_nxt;
    end
  end

endmodule
`default_nettype wire

// ----- hw/rtl/asn1ts_out_stage.sv -----
`default_nettype none
module asn1ts_out_stage
  import asn1ts_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire asn1ts_emit_t emit,
  output logic              can_load,
  output logic              out_valid,
  input  wire logic         out_ready,
  output asn1ts_out_t       out_data
);

  logic        valid_r;
  asn1ts_out_t data_r;

  assign can_load  = !valid_r || out_ready;
  assign out_valid = valid_r;
  assign out_data  = data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (emit.load) begin
      valid_r <= 1'b1;
    end else if (out_ready) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit.load) begin
      data_r <= emit.res;
    end
  end

endmodule
`default_nettype wire

// ----- hw/rtl/asn1_time_string_parser.sv -----
// Parses one DER UTCTime or GeneralizedTime value a byte per word: the tag
// word (first set), then the content characters, the final one with last set.
// One word is taken every cycle while no last word waits. A word is registered
// in the input register, then a single combinational pass updates the digit
// accumulators and, on the last word, checks format, ranges and month length
// into the result register. Only a last word waits when the result register
// is still full. Status 1 is an unknown tag, status 2 a bad format or date;
// all date fields are zero then.
`default_nettype none
module asn1_time_string_parser
  import asn1ts_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire asn1ts_in_t  in_data,
  output logic             out_valid,
  input  wire logic        out_ready,
  output asn1ts_out_t      out_data
);

  asn1ts_step_t step;
  asn1ts_emit_t emit;
  logic         take;
  logic         can_load;

  asn1ts_in_stage u_in (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .take     (take),
    .step     (step)
  );

  asn1ts_core u_core (
    .clk      (clk),
    .rst_n    (rst_n),
    .step     (step),
    .can_load (can_load),
    .take     (take),
    .emit     (emit)
  );

  asn1ts_out_stage u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .emit      (emit),
    .can_load  (can_load),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule
`default_nettype wire

// ----- hw/rtl/asn1ts_checker.sv -----
`default_nettype none
`include "asn1_time_string_parser_macros.svh"
module asn1ts_checker
  import asn1ts_pkg::*;
(
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_valid,
  input wire logic        in_ready,
  input wire asn1ts_in_t  in_data,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire asn1ts_out_t out_data
);

  logic date_zero;

  assign date_zero = out_data.year == 14'd0 && out_data.month == 4'd0 &&
                     out_data.day == 5'd0 && out_data.hour == 5'd0 &&
                     out_data.minute == 6'd0 && out_data.second == 6'd0;

  `A1TS_ASSERT_ALWAYS(a_rst_idle, !rst_n |=> !out_valid, "result valid after reset")

  `A1TS_ASSERT(a_in_hold, in_valid && !in_ready |=> in_valid && $stable(in_data), "input word changed")

  `A1TS_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(out_data), "result lost")

  `A1TS_ASSERT(a_status_code, out_valid |-> out_data.status <= ST_FMT, "undefined status code")

  `A1TS_ASSERT(a_err_zero, out_valid && out_data.status != ST_OK |-> date_zero, "error with date")

endmodule

bind asn1_time_string_parser asn1ts_checker u_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
`default_nettype wire

// ----- test/tb.sv -----
`timescale 1ns / 1ps
module tb;
  import asn1ts_pkg::*;

  localparam logic [7:0] TAG_JUNK = 8'hFF;

  localparam asn1ts_out_t RES_NONE = '{ST_OK, 14'd0, 4'd0, 5'd0, 5'd0, 6'd0, 6'd0};
  localparam asn1ts_out_t RES_TAG  = '{ST_TAG, 14'd0, 4'd0, 5'd0, 5'd0, 6'd0, 6'd0};
  localparam asn1ts_out_t RES_FMT  = '{ST_FMT, 14'd0, 4'd0, 5'd0, 5'd0, 6'd0, 6'd0};
  localparam asn1ts_out_t RES_LATE = '{ST_OK, 14'd1999, 4'd12, 5'd31, 5'd23, 6'd59, 6'd59};

  typedef struct packed {
    asn1ts_in_t  w;
    logic        typed;
    asn1ts_out_t res;
  } dir_row_t;

  dir_row_t dir_tab [21] = '{
    '{'{TAG_JUNK, 1'b1, 1'b1}, 1'b1, RES_TAG},
    '{'{TAG_GEN, 1'b1, 1'b1}, 1'b1, RES_FMT},
    // unknown tag: content is ignored
    '{'{8'h00, 1'b1, 1'b0}, 1'b0, RES_NONE},
    '{'{8'hFF, 1'b0, 1'b1}, 1'b1, RES_TAG},
    // value dropped by a new tag
    '{'{TAG_GEN, 1'b1, 1'b0}, 1'b0, RES_NONE},
    '{'{TAG_UTC, 1'b1, 1'b1}, 1'b1, RES_FMT},
    '{'{TAG_UTC, 1'b1, 1'b0}, 1'b0, RES_NONE},
    '{'{8'h00, 1'b0, 1'b1}, 1'b1, RES_FMT},
    // no tag: parsed as UTCTime, 991231235959Z
    '{'{"9", 1'b0, 1'b0}, 1'b0, RES_NONE},
    '{'{"9", 1'b0, 1'b0}, 1'b0, RES_NONE},
    '{'{"1", 1'b0, 1'b0}, 1'b0, RES_NONE},
    '{'{"2", 1'b0, 1'b0}, 1'b0, RES_NONE},
    '{'{"3", 1'b0, 1'b0}, 1'b0, RES_NONE},
    '{'{"1", 1'b0, 1'b0}, 1'b0, RES_NONE},
    '{'{"2", 1'b0, 1'b0}, 1'b0, RES_NONE},
    '{'{"3", 1'b0, 1'b0}, 1'b0, RES_NONE},
    '{'{"5", 1'b0, 1'b0}, 1'b0, RES_NONE},
    '{'{"9", 1'b0, 1'b0}, 1'b0, RES_NONE},
    '{'{"5", 1'b0, 1'b0}, 1'b0, RES_NONE},
    '{'{"9", 1'b0, 1'b0}, 1'b0, RES_NONE},
    '{'{CHAR_Z, 1'b0, 1'b1}, 1'b1, RES_LATE}
  };

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  asn1ts_in_t  in_data = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  asn1ts_out_t out_data;

  logic        word_typed = 1'b0;
  asn1ts_out_t word_res = '0;

  int idle_pct = 0;
  int stall_pct = 0;
  int n_bad = 0;

  asn1ts_out_t dates_due[$];
  asn1ts_in_t  stim_q[$];
  logic [7:0]  chars[$];

  // parser state mirror
  logic [4:0]  cpos;
  logic        gen_yr;
  logic [1:0]  first_err;
  logic [13:0] acc_yr;
  logic [6:0]  acc_mon, acc_day, acc_hr, acc_min, acc_sec;

  always #1 clk = ~clk;

  asn1_time_string_parser i_dut (
    .clk,
    .rst_n,
    .in_valid,
    .in_ready,
    .in_data,
    .out_valid,
    .out_ready,
    .out_data
  );

  function automatic int month_days(int m, int y);
    case (m)
      1, 3, 5, 7, 8, 10, 12: return 31;
      4, 6, 9, 11: return 30;
      2: return ((y % 4 == 0 && y % 100 != 0) || y % 400 == 0) ? 29 : 28;
      default: return 0;
    endcase
  endfunction

  task automatic clear_parse();
    cpos = '0;
    gen_yr = 1'b0;
    first_err = ST_OK;
    acc_yr = '0;
    acc_mon = '0;
    acc_day = '0;
    acc_hr = '0;
    acc_min = '0;
    acc_sec = '0;
  endtask

  task automatic parse_time_byte(input asn1ts_in_t w, output bit done,
                                 output asn1ts_out_t r);
    int ylen, d, p, yr, mlen;
    logic [1:0] st;
    done = w.last;
    r = '0;
    ylen = gen_yr ? 4 : 2;
    p = cpos;
    if (w.first) begin
      clear_parse();
      if (w.data_byte == TAG_GEN) begin
        gen_yr = 1'b1;
      end else if (w.data_byte != TAG_UTC) begin
        first_err = ST_TAG;
      end
    end else begin
      if (first_err == ST_OK) begin
        if (p < ylen + 10) begin
          if (w.data_byte < CHAR_0 || w.data_byte > CHAR_9) begin
            first_err = ST_FMT;
          end else begin
            d = w.data_byte - CHAR_0;
            if (p < ylen) begin
              acc_yr = 14'(acc_yr * 10 + d);
            end else begin
              case ((p - ylen) / 2)
                0: acc_mon = 7'(acc_mon * 10 + d);
                1: acc_day = 7'(acc_day * 10 + d);
                2: acc_hr = 7'(acc_hr * 10 + d);
                3: acc_min = 7'(acc_min * 10 + d);
                default: acc_sec = 7'(acc_sec * 10 + d);
              endcase
            end
          end
        end else if (!(p == ylen + 10 && w.data_byte == CHAR_Z)) begin
          first_err = ST_FMT;
        end
      end
      if (cpos != POS_MAX) cpos = cpos + 5'd1;
    end
    if (!w.last) return;

    ylen = gen_yr ? 4 : 2;
    p = cpos;
    st = first_err;
    yr = acc_yr;
    if (st == ST_OK && p != ylen + 10 && p != ylen + 11) st = ST_FMT;
    if (st == ST_OK) begin
      if (!gen_yr) yr = (yr < 50) ? yr + 2000 : yr + 1900;
      mlen = month_days(acc_mon, yr);
      if (yr > 9999 || acc_hr > 23 || acc_min > 59 || acc_sec > 59 || mlen == 0 ||
          acc_day < 1 || acc_day > mlen) st = ST_FMT;
    end
    r.status = st;
    if (st == ST_OK) begin
      r.year = 14'(yr);
      r.month = 4'(acc_mon);
      r.day = 5'(acc_day);
      r.hour = 5'(acc_hr);
      r.minute = 6'(acc_min);
      r.second = 6'(acc_sec);
    end
    clear_parse();
  endtask

  function automatic int edge_val(int top);
    case ($urandom_range(9))
      0: return top;
      1: return top + 1;
      2: return 0;
      3: return $urandom_range(99);
      default: return $urandom_range(top);
    endcase
  endfunction

  task automatic push2(int v);
    chars.push_back(8'(CHAR_0 + (v / 10) % 10));
    chars.push_back(8'(CHAR_0 + v % 10));
  endtask

  task automatic trim(int k);
    while (chars.size() > k) void'(chars.pop_back());
  endtask

  task automatic gen_value();
    int kind, yr, full, mo, dy, n;
    bit gen_t, headless;
    logic [7:0] tag;
    kind = $urandom_range(99);
    headless = (kind >= 81 && kind < 88);
    gen_t = headless ? 1'b0 : 1'($urandom_range(1));
    if (gen_t) begin
      case ($urandom_range(3))
        0: yr = 100 * $urandom_range(99);
        1: yr = 4 * $urandom_range(2499);
        default: yr = $urandom_range(9999);
      endcase
      full = yr;
    end else begin
      yr = $urandom_range(99);
      full = (yr < 50) ? yr + 2000 : yr + 1900;
    end
    mo = ($urandom_range(3) == 0) ? 2 : edge_val(12);
    n = month_days(mo, full);
    case ($urandom_range(9))
      0: dy = n;
      1: dy = n + 1;
      2: dy = 0;
      3: dy = $urandom_range(99);
      default: dy = (n == 0) ? $urandom_range(99) : $urandom_range(1, n);
    endcase

    chars.delete();
    if (gen_t) begin
      push2(yr / 100);
      push2(yr % 100);
    end else begin
      push2(yr);
    end
    push2(mo);
    push2(dy);
    push2(edge_val(23));
    push2(edge_val(59));
    push2(edge_val(59));
    if ($urandom_range(1)) chars.push_back(CHAR_Z);

    tag = gen_t ? TAG_GEN : TAG_UTC;
    if (kind < 55) begin
    end else if (kind < 63) begin
      chars[$urandom_range(chars.size() - 1)] =
        $urandom_range(1) ? CHAR_Z : 8'($urandom_range(255));
    end else if (kind < 69) begin
      trim($urandom_range(chars.size() - 1));
    end else if (kind < 75) begin
      repeat ($urandom_range(1, 3)) chars.push_back(8'($urandom_range(255)));
    end else if (kind < 81) begin
      do tag = 8'($urandom_range(255)); while (tag == TAG_UTC || tag == TAG_GEN);
      trim($urandom_range(chars.size()));
    end else if (kind < 88) begin
    end else if (kind < 94) begin
      stim_q.push_back('{($urandom_range(1) ? TAG_UTC : TAG_GEN), 1'b1, 1'b0});
      repeat ($urandom_range(6)) stim_q.push_back('{8'(CHAR_0 + $urandom_range(9)), 1'b0, 1'b0});
    end else begin
      chars.delete();
      repeat ($urandom_range(15, 40))
        chars.push_back(($urandom_range(9) == 0) ? 8'($urandom_range(255))
                                                 : 8'(CHAR_0 + $urandom_range(9)));
    end

    if (!headless) stim_q.push_back('{tag, 1'b1, 1'(chars.size() == 0)});
    foreach (chars[i]) stim_q.push_back('{chars[i], 1'b0, 1'(i == chars.size() - 1)});
  endtask

  // called in the time step of a clock edge; returns at the edge that takes the word
  task automatic send_word(asn1ts_in_t w, logic typed, asn1ts_out_t res);
    if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < idle_pct);
    end
    in_valid <= 1'b1;
    in_data <= w;
    word_typed <= typed;
    word_res <= res;
    do @(posedge clk); while (!in_ready);
  endtask

  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk) begin
    asn1ts_out_t pred, want;
    bit done;
    if (rst_n && in_valid && in_ready) begin
      parse_time_byte(in_data, done, pred);
      if (done) dates_due.push_back(word_typed ? word_res : pred);
    end
    if (rst_n && out_valid && out_ready) begin
      if (dates_due.size() == 0) begin
        n_bad++;
        if (n_bad <= 10) $display("unexpected result word, status %0d", out_data.status);
      end else begin
        want = dates_due.pop_front();
        if (want.status !== out_data.status || want.year !== out_data.year ||
            want.month !== out_data.month || want.day !== out_data.day ||
            want.hour !== out_data.hour || want.minute !== out_data.minute ||
            want.second !== out_data.second) begin
          n_bad++;
          if (n_bad <= 10)
            $display("mismatch: exp st=%0d %0d-%0d-%0d %0d:%0d:%0d got st=%0d %0d-%0d-%0d %0d:%0d:%0d",
                     want.status, want.year, want.month, want.day,
                     want.hour, want.minute, want.second,
                     out_data.status, out_data.year, out_data.month, out_data.day,
                     out_data.hour, out_data.minute, out_data.second);
        end
      end
    end
  end

  initial begin
    int sent;
    clear_parse();
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    foreach (dir_tab[i]) send_word(dir_tab[i].w, dir_tab[i].typed, dir_tab[i].res);

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin idle_pct = 0; stall_pct = 0; end
        1: begin idle_pct = 57; stall_pct = 0; end
        2: begin idle_pct = 0; stall_pct = 57; end
        default: begin idle_pct = 16; stall_pct = 16; end
      endcase
      sent = 0;
      while (sent < 200) begin
        gen_value();
        while (stim_q.size() != 0) begin
          send_word(stim_q.pop_front(), 1'b0, RES_NONE);
          sent++;
        end
      end
    end

    in_valid <= 1'b0;
    @(posedge clk);
    while (dates_due.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (n_bad == 0 && dates_due.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    #1000000;
    $display("timeout");
    $display("*** FAILED ***");
    $finish;
  end

endmodule

// ----- sim.f -----
+incdir+hw/rtl
hw/rtl/asn1ts_pkg.sv
hw/rtl/asn1ts_in_stage.sv
hw/rtl/asn1ts_core.sv
hw/rtl/asn1ts_out_stage.sv
hw/rtl/asn1_time_string_parser.sv
hw/rtl/asn1ts_checker.sv
test/tb.sv
